/* rtl/mvcp_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI volume parser package
// Shared types and constants for the MIDI volume control-change parser.
// ----------------------------------------------------------------------------
package mvcp_pkg;

    localparam logic [7:0] STATUS_MASK      = 8'h80;
    localparam logic [7:0] STATUS_CC_CH1    = 8'hB0;
    localparam logic [6:0] CTRL_VOLUME      = 7'd7;
    localparam logic [7:0] VOLUME_OFFSET_DB = 8'd99;

    // Configuration register indexes.
    localparam logic CFG_VOLUME_MIN = 1'b0;
    localparam logic CFG_VOLUME_MAX = 1'b1;

    localparam logic signed [7:0] VOLUME_MIN_RESET = -8'sd99;
    localparam logic signed [7:0] VOLUME_MAX_RESET = 8'sd28;

    typedef enum logic [1:0] {
        ST_IDLE        = 2'd0,
        ST_HAVE_STATUS = 2'd1,
        ST_HAVE_DATA1  = 2'd2
    } t_parse_state;

    // One candidate volume from the parser, in whole dB.
    typedef struct packed {
        logic              valid;
        logic signed [7:0] db;
    } t_volume_push;

    typedef struct packed {
        logic full;
        logic empty;
        logic pop;
    } t_queue_status;

endpackage

/* rtl/mvcp_front.sv */
// ----------------------------------------------------------------------------
// MIDI parser front end
// Accepts received bytes, tracks the message and forwards volume candidates.
// ----------------------------------------------------------------------------
module mvcp_front
    import mvcp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  logic [7:0]   i_rx_byte,
    output t_volume_push o_push
);

    t_parse_state r_state, n_state;
    logic [7:0]   r_status, n_status;
    logic [6:0]   r_first, n_first;
    logic         is_status;

    assign is_status = (i_rx_byte & STATUS_MASK) != 8'h00;

    // Next state.
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_first  = r_first;
        if (i_accept) begin
            if (is_status) begin
                n_status = i_rx_byte;
                n_state  = ST_HAVE_STATUS;
            end else begin
                unique case (r_state)
                    ST_HAVE_STATUS: begin
                        n_first = i_rx_byte[6:0];
                        n_state = ST_HAVE_DATA1;
                    end
                    ST_HAVE_DATA1: n_state = ST_IDLE;
                    default:       n_state = ST_IDLE;
                endcase
            end
        end
    end

    // Outputs.
    always_comb begin
        o_push.db    = $signed({1'b0, i_rx_byte[6:0]} - VOLUME_OFFSET_DB);
        o_push.valid = 1'b0;
        unique case (r_state)
            ST_HAVE_DATA1: begin
                o_push.valid = i_accept && !is_status &&
                               (r_status == STATUS_CC_CH1) && (r_first == CTRL_VOLUME);
            end
            default: o_push.valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_status <= 8'h00;
            r_first  <= 7'h00;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_first  <= n_first;
        end
    end

endmodule

/* rtl/mvcp_queue.sv */
// ----------------------------------------------------------------------------
// MIDI parser volume queue
// Small FIFO that decouples the parser from the window check and output.
// ----------------------------------------------------------------------------
module mvcp_queue
    import mvcp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_volume_push      i_push,
    input  logic              i_pop,
    output logic signed [7:0] o_db,
    output t_queue_status     o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [7:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]     r_count, n_count;
    logic              do_push, do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_status.pop   = do_pop;
    assign do_push        = i_push.valid && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_db           = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.db;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* rtl/mvcp_back.sv */
// ----------------------------------------------------------------------------
// MIDI parser back end
// Holds the volume window, checks candidates and drives the output register.
// ----------------------------------------------------------------------------
module mvcp_back
    import mvcp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [7:0]        i_cfg_wdata,
    input  logic              i_queue_empty,
    input  logic signed [7:0] i_db,
    output logic              o_pop,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [9:0]        o_volume_quarter_db
);

    logic signed [7:0] r_min_db, r_max_db;
    logic              r_valid, n_valid;
    logic [9:0]        r_volume;
    logic              in_window;

    assign in_window = (i_db >= r_min_db) && (i_db <= r_max_db);

    // A candidate leaves the queue whenever the output register is free or drains.
    assign o_pop = !i_queue_empty && (!r_valid || i_out_ready);

    always_comb begin
        if (o_pop) begin
            n_valid = in_window;
        end else begin
            n_valid = r_valid && !i_out_ready;
        end
    end

    assign o_out_valid         = r_valid;
    assign o_volume_quarter_db = r_volume;

    always_ff @(posedge i_clk) begin
        if (o_pop && in_window) begin
            r_volume <= {i_db, 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_min_db <= VOLUME_MIN_RESET;
            r_max_db <= VOLUME_MAX_RESET;
        end else begin
            r_valid <= n_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_VOLUME_MIN: r_min_db <= $signed(i_cfg_wdata);
                    CFG_VOLUME_MAX: r_max_db <= $signed(i_cfg_wdata);
                    default:        r_min_db <= r_min_db;
                endcase
            end
        end
    end

endmodule

/* rtl/midi_volume_cc_parser_unit.sv */
// ----------------------------------------------------------------------------
// MIDI volume control-change parser
// Top level: byte stream in, accepted master volume in quarter dB out.
// ----------------------------------------------------------------------------
// The block takes MIDI bytes and emits a volume, in quarter dB, for the second data
// byte of a channel-1 volume control change whose level falls inside the configured
// window; the volume passes through the candidate queue and the output register. A
// byte is taken whenever the candidate queue between the parser and the output stage
// has room (DEPTH entries), so with the output side ready the input runs at one byte
// a cycle. Write the window registers only while no message is in flight.
module midi_volume_cc_parser_unit
    import mvcp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] volume_quarter_db, [15:10] zero
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);

    t_volume_push      push;
    t_queue_status     q_status;
    logic signed [7:0] q_db;
    logic              pop;
    logic              accept;
    logic [9:0]        volume;

    assign s_axis_tready = !q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    mvcp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (s_axis_tdata),
        .o_push    (push)
    );

    mvcp_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_db     (q_db),
        .o_status (q_status)
    );

    mvcp_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_addr          (i_cfg_addr),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_queue_empty       (q_status.empty),
        .i_db                (q_db),
        .o_pop               (pop),
        .i_out_ready         (m_axis_tready),
        .o_out_valid         (m_axis_tvalid),
        .o_volume_quarter_db (volume)
    );

    assign m_axis_tdata = {6'b000000, volume};

    // A new result only appears after a candidate left the queue.
    a_valid_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(q_status.pop))
        else $error("output valid rose without a queue pop");

    // The queue is never both full and empty.
    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty at once");

    // A full queue takes no push, so the input is held off.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> !s_axis_tready)
        else $error("input ready while queue is full");

    // Results are whole dB scaled by four.
    a_quarter_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == 2'b00))
        else $error("volume not a multiple of four quarter dB");

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// MIDI volume control-change parser testbench
// Drives MIDI byte streams into the parser and checks every volume item it
// emits against a cycle-free model of the message parser and volume window.
// The run covers directed parser corner cases, a long output stall with the
// input pushing into the full block, and random message traffic under a
// sequence of window settings, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mvcp_pkg::*;

    localparam int TX_GAP_MAX        = 4;
    localparam int RX_GAP_MAX        = 4;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int DRAIN_CYCLES      = 16;
    localparam int DRAIN_LIMIT       = 5000;
    localparam int RANDOM_ITEMS      = 1550;
    localparam int PHASE_ITEMS       = 150;
    localparam int MAX_PRINTS        = 40;
    localparam int TIMEOUT_NS        = 200000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [9:0] volume_quarter_db, [15:10] zero
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_addr    = CFG_VOLUME_MIN;
    logic [7:0]  i_cfg_wdata   = 8'h00;

    // Parser model state and volume window.
    t_parse_state      cc_state;
    logic [7:0]        cc_status;
    logic [6:0]        cc_ctrl;
    logic signed [7:0] win_min;
    logic signed [7:0] win_max;
    logic [9:0]        vol_expected[$];

    int  bytes_sent     = 0;
    int  bytes_accepted = 0;
    int  vols_checked   = 0;
    int  windows_used   = 0;
    int  n_errors       = 0;
    bit  tx_steady      = 1'b0;
    bit  rx_steady      = 1'b0;
    int  hold_req       = 0;
    int  hold_seen      = 0;
    int  rx_gap         = 0;

    midi_volume_cc_parser_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_error(input string msg);
        if (n_errors < MAX_PRINTS) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
        n_errors++;
    endtask

    // Advances the parser model by one byte; returns 1 when a volume is due.
    function automatic bit parse_rx_byte(input logic [7:0] b, output logic [9:0] vol);
        int db;
        bit hit;
        hit = 1'b0;
        vol = '0;
        if ((b & STATUS_MASK) != 8'h00) begin
            cc_status = b;
            cc_state  = ST_HAVE_STATUS;
        end else if (cc_state == ST_HAVE_STATUS) begin
            cc_ctrl  = b[6:0];
            cc_state = ST_HAVE_DATA1;
        end else if (cc_state == ST_HAVE_DATA1) begin
            cc_state = ST_IDLE;
            if (cc_status == STATUS_CC_CH1 && cc_ctrl == CTRL_VOLUME) begin
                db = int'(b) - int'(VOLUME_OFFSET_DB);
                if (db >= int'(win_min) && db <= int'(win_max)) begin
                    vol = 10'(db * 4);
                    hit = 1'b1;
                end
            end
        end else begin
            cc_state = ST_IDLE;
        end
        return hit;
    endfunction

    // Output check first, then register writes, then the accepted input byte.
    always @(posedge i_clk) begin : predict_and_check
        logic [9:0] vol;
        logic [9:0] want;
        if (!i_rst_n) begin
            cc_state  = ST_IDLE;
            cc_status = '0;
            cc_ctrl   = '0;
            win_min   = VOLUME_MIN_RESET;
            win_max   = VOLUME_MAX_RESET;
            vol_expected.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (vol_expected.size() == 0) begin
                    report_error($sformatf("volume item 0x%04h with none expected",
                                           m_axis_tdata));
                end else begin
                    want = vol_expected.pop_front();
                    vols_checked++;
                    if (m_axis_tdata[9:0] !== want) begin
                        report_error($sformatf("volume got %0d expected %0d",
                                               $signed(m_axis_tdata[9:0]), $signed(want)));
                    end
                    if (m_axis_tdata[15:10] !== 6'b0) begin
                        report_error($sformatf("padding bits got 0x%02h",
                                               m_axis_tdata[15:10]));
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_VOLUME_MIN) begin
                    win_min = i_cfg_wdata;
                end else begin
                    win_max = i_cfg_wdata;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                bytes_accepted++;
                if (parse_rx_byte(s_axis_tdata, vol)) begin
                    vol_expected.push_back(vol);
                end
            end
        end
    end

    // Output side: random stalls after each item and now and then while idle,
    // plus a long hold-off whenever a test asks for one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_gap = 0;
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                rx_gap    = LONG_STALL_CYCLES;
            end else if (m_axis_tvalid && m_axis_tready) begin
                rx_gap = rx_steady ? 0 : $urandom_range(0, RX_GAP_MAX);
            end else if (rx_gap > 0) begin
                rx_gap--;
            end else if (!rx_steady && $urandom_range(0, 7) == 0) begin
                rx_gap = $urandom_range(1, RX_GAP_MAX);
            end
            m_axis_tready <= (rx_gap == 0);
        end
    end

    // Offers one byte after a random gap and returns once ready reads high after an edge.
    // Valid stays high on return so back-to-back bytes follow without an idle gap.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, TX_GAP_MAX);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Stops the input and waits until every expected volume has come out or DRAIN_LIMIT runs out.
    task automatic wait_drained();
        int guard;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (vol_expected.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Only called with the block drained.
    task automatic write_window(input logic signed [7:0] lo, input logic signed [7:0] hi);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_VOLUME_MIN;
        i_cfg_wdata <= lo;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_VOLUME_MAX;
        i_cfg_wdata <= hi;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        windows_used++;
    endtask

    task automatic send_volume_cc(input logic [6:0] level);
        send_byte(STATUS_CC_CH1);
        send_byte({1'b0, CTRL_VOLUME});
        send_byte({1'b0, level});
    endtask

    task automatic test_parser_cases();
        // Data bytes with no status are dropped.
        send_byte(8'h00);
        send_byte(8'h7F);
        // Lowest and highest level under the reset window.
        send_volume_cc(7'd0);
        send_volume_cc(7'd127);
        // A repeated status restarts the message; level 99 is 0 dB.
        send_byte(STATUS_CC_CH1);
        send_volume_cc(7'd99);
        // A status byte after the first data byte aborts the message.
        send_byte(STATUS_CC_CH1);
        send_byte({1'b0, CTRL_VOLUME});
        send_byte(8'h90);
        send_byte({1'b0, CTRL_VOLUME});
        send_byte(8'h40);
        // Another status, then another controller: consumed, no volume.
        send_byte(8'hFF);
        send_byte({1'b0, CTRL_VOLUME});
        send_byte(8'h10);
        send_byte(STATUS_CC_CH1);
        send_byte(8'h08);
        send_byte(8'h50);
        wait_drained();
    endtask

    task automatic test_output_stall();
        write_window(-8'sd128, 8'sd127);
        tx_steady = 1'b1;
        hold_req++;
        repeat (20) send_volume_cc(7'($urandom_range(0, 127)));
        wait_drained();
        tx_steady = 1'b0;
    endtask

    task automatic send_random_message();
        logic [7:0] status;
        logic [6:0] ctrl;
        int pick;
        pick   = $urandom_range(0, 99);
        status = ($urandom_range(0, 3) != 0) ? STATUS_CC_CH1 : 8'($urandom_range(128, 255));
        ctrl   = ($urandom_range(0, 3) != 0) ? CTRL_VOLUME : 7'($urandom_range(0, 127));
        if (pick < 75) begin
            send_byte(status);
            send_byte({1'b0, ctrl});
            send_byte(8'($urandom_range(0, 127)));
        end else if (pick < 87) begin
            send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 94) begin
            send_byte(status);
            send_byte({1'b0, ctrl});
        end else begin
            send_byte(status);
        end
    endtask

    task automatic test_random_traffic();
        int start;
        int phase;
        int lo;
        int hi;
        start = bytes_sent;
        phase = 0;
        while (bytes_sent - start < RANDOM_ITEMS) begin
            wait_drained();
            // The first phases use fixed edge windows, then random ones.
            case (phase)
                0: begin lo = 0;    hi = 0;    end
                1: begin lo = -128; hi = 127;  end
                2: begin lo = 127;  hi = -128; end
                3: begin lo = 28;   hi = 28;   end
                4: begin lo = -99;  hi = -99;  end
                default: begin
                    case ($urandom_range(0, 3))
                        0: begin
                            lo = int'($urandom_range(0, 255)) - 128;
                            hi = int'($urandom_range(0, 255)) - 128;
                        end
                        1: begin
                            lo = int'($urandom_range(0, 127)) - 99;
                            hi = lo + int'($urandom_range(0, 28 - lo));
                        end
                        2: begin
                            lo = int'($urandom_range(0, 127)) - 99;
                            hi = lo + int'($urandom_range(0, 5));
                        end
                        default: begin
                            lo = int'(VOLUME_MIN_RESET);
                            hi = int'(VOLUME_MAX_RESET);
                        end
                    endcase
                end
            endcase
            write_window(8'(lo), 8'(hi));
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            while (bytes_sent - start < (phase + 1) * PHASE_ITEMS
                   && bytes_sent - start < RANDOM_ITEMS) begin
                send_random_message();
            end
            phase++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_parser_cases();
        test_output_stall();
        test_random_traffic();
        wait_drained();
        if (vol_expected.size() != 0) begin
            report_error($sformatf("%0d expected volume items never came out",
                                   vol_expected.size()));
        end
        $display("Run covered %0d accepted bytes, %0d volume items and %0d window settings.",
                 bytes_accepted, vols_checked, windows_used);
        $display("Parser corner cases, a long output stall and random traffic were run.");
        if (n_errors == 0) begin
            $display("midi_volume_cc_parser_unit test passed");
        end else begin
            $display("midi_volume_cc_parser_unit test failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d volume items still expected.", vol_expected.size());
        $display("midi_volume_cc_parser_unit test failed");
        $finish;
    end

endmodule
